// File: hw/rtl/bdgn_pkg.sv
// shared types and constants for the box decode and greedy nms block
`timescale 1ns / 1ps
package bdgn_pkg;

	localparam int unsigned COORD_W = 14;
	localparam int unsigned SCORE_W = 16;
	localparam int unsigned CLASS_W = 8;
	localparam int unsigned PAD_W   = 10;
	localparam int unsigned EDGE_W  = 16;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 16;
	localparam int unsigned OUT_LIMIT = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCORE_THR = 3'd0,
		REG_IOU_THR   = 3'd1,
		REG_PAD_X     = 3'd2,
		REG_PAD_Y     = 3'd3,
		REG_SCALE     = 3'd4
	} cfg_reg_t;

	localparam logic [15:0] SCORE_THR_RST = 16'd16384;
	localparam logic [15:0] IOU_THR_RST   = 16'd29491;
	localparam logic [15:0] SCALE_RST     = 16'd4096;

	// one stored candidate, decoded
	typedef struct packed {
		logic [EDGE_W-1:0]  left;
		logic [EDGE_W-1:0]  top;
		logic [EDGE_W-1:0]  width;
		logic [EDGE_W-1:0]  height;
		logic [SCORE_W-1:0] score;
		logic [CLASS_W-1:0] cls;
	} entry_t;

endpackage

// File: hw/rtl/bdgn_if.sv
// channel interfaces: candidate input, result output, register writes
`timescale 1ns / 1ps
interface bdgn_in_if;
	logic                           valid;
	logic                           ready;
	logic [bdgn_pkg::COORD_W-1:0]  center_x;
	logic [bdgn_pkg::COORD_W-1:0]  center_y;
	logic [bdgn_pkg::COORD_W-1:0]  box_w;
	logic [bdgn_pkg::COORD_W-1:0]  box_h;
	logic [bdgn_pkg::SCORE_W-1:0]  score;
	logic [bdgn_pkg::CLASS_W-1:0]  class_in;
	logic                           last_candidate;
	modport source (output valid, center_x, center_y, box_w, box_h, score, class_in,
		last_candidate, input ready);
	modport sink (input valid, center_x, center_y, box_w, box_h, score, class_in,
		last_candidate, output ready);
endinterface

interface bdgn_out_if;
	logic                                valid;
	logic                                ready;
	logic [bdgn_pkg::CLASS_W-1:0]       class_out;
	logic [bdgn_pkg::SCORE_W-1:0]       confidence;
	logic signed [bdgn_pkg::EDGE_W-1:0] left;
	logic signed [bdgn_pkg::EDGE_W-1:0] top;
	logic [bdgn_pkg::EDGE_W-1:0]        width;
	logic [bdgn_pkg::EDGE_W-1:0]        height;
	logic                                last;
	logic                                none_kept;
	logic                                overflow;
	modport source (output valid, class_out, confidence, left, top, width, height, last,
		none_kept, overflow, input ready);
	modport sink (input valid, class_out, confidence, left, top, width, height, last,
		none_kept, overflow, output ready);
endinterface

interface bdgn_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [bdgn_pkg::CFG_IDX_W-1:0] index;
	logic [bdgn_pkg::CFG_DAT_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/bdgn_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module bdgn_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: hw/rtl/box_decode_greedy_nms_top.sv
// candidate decode, store and greedy nms: one shared multiplier under a sequencer
// an accepted candidate runs 4 multiplies and a store write, or neither if it is dropped
// frame end: a scan is a mark step, then per open entry a read, geometry, the intersection, area
// and threshold multiplies and a compare (the multiplies are skipped once kept or suppressed), and
// an emit step; a first scan finds the top box, as each result waits for its transfer before the next scan
// intake is closed from the last candidate until the frame's final result transfers
// async reset clears control and config registers only; the stores need no clearing pass
`timescale 1ns / 1ps
module box_decode_greedy_nms_top #(
	parameter int unsigned MAX_CANDIDATES = 64
) (
	input  logic   clk,
	input  logic   arst_n,
	bdgn_in_if.sink    in_ch,
	bdgn_out_if.source out_ch,
	bdgn_cfg_if.sink   cfg
);
	localparam int unsigned AW = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
	localparam int unsigned CW = $clog2(MAX_CANDIDATES + 1);
	localparam int unsigned EW = $bits(bdgn_pkg::entry_t);
	localparam int unsigned OCW = $clog2(bdgn_pkg::OUT_LIMIT);

	typedef enum logic [14:0] {
		S_IDLE = 15'b000000000000001,
		S_LL   = 15'b000000000000010,
		S_LT   = 15'b000000000000100,
		S_LW   = 15'b000000000001000,
		S_LH   = 15'b000000000010000,
		S_LWR  = 15'b000000000100000,
		S_MARK = 15'b000000001000000,
		S_RD   = 15'b000000010000000,
		S_GEO  = 15'b000000100000000,
		S_M1   = 15'b000001000000000,
		S_M2   = 15'b000010000000000,
		S_M3   = 15'b000100000000000,
		S_CMP  = 15'b001000000000000,
		S_EMIT = 15'b010000000000000,
		S_OUT  = 15'b100000000000000
	} state_t;

	state_t state_q;

	// configuration
	logic [15:0] score_thr_q, iou_thr_q, scale_q;
	logic [9:0]  pad_x_q, pad_y_q;

	// latched candidate
	logic [13:0] cx_q, cy_q, bw_q, bh_q;
	logic [15:0] sc_q;
	logic [7:0]  cls_q;
	logic        lastc_q;
	logic [15:0] dl_q, dt_q, dw_q;

	logic [CW-1:0]  cnt_q, idx_q;
	logic           ovf_q, have_best_q, found_q, skip_q, ovl_q;
	logic [OCW-1:0] out_cnt_q;

	bdgn_pkg::entry_t best_q, nxt_q, ent_q;
	logic [AW-1:0]    best_idx_q, nxt_idx_q;
	logic [31:0]      best_area_q, nxt_area_q, ent_area_q;
	logic [31:0]      inter_q;
	logic signed [17:0] iw_q, ih_q;

	// shared multiplier
	logic signed [17:0] mul_a;
	logic signed [34:0] mul_b;
	logic signed [52:0] prod_q;

	// output register
	bdgn_pkg::entry_t o_q;
	logic o_last_q, o_none_q;

	// rams
	logic          ram_we, done_we, done_wd;
	logic [AW-1:0] done_wa;
	bdgn_pkg::entry_t ram_wd, ram_rd;
	logic [EW-1:0] ram_rd_raw;
	logic          done_rd;

	logic in_xfer, out_xfer;
	assign in_xfer  = in_ch.valid && in_ch.ready;
	assign out_xfer = out_ch.valid && out_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE);
	assign cfg.ready   = 1'b1;

	bdgn_ram #(.WIDTH(EW), .DEPTH(MAX_CANDIDATES)) u_box_ram (
		.clk(clk), .we(ram_we), .waddr(cnt_q[AW-1:0]), .wdata(ram_wd),
		.raddr(idx_q[AW-1:0]), .rdata(ram_rd_raw)
	);
	assign ram_rd = bdgn_pkg::entry_t'(ram_rd_raw);

	bdgn_ram #(.WIDTH(1), .DEPTH(MAX_CANDIDATES)) u_done_ram (
		.clk(clk), .we(done_we), .waddr(done_wa), .wdata(done_wd),
		.raddr(idx_q[AW-1:0]), .rdata(done_rd)
	);

	// decode operands
	logic signed [17:0] vx, vy;
	assign vx = $signed({3'b000, cx_q, 1'b0}) - $signed({4'b0000, bw_q})
		- $signed({3'b000, pad_x_q, 5'b00000});
	assign vy = $signed({3'b000, cy_q, 1'b0}) - $signed({4'b0000, bh_q})
		- $signed({3'b000, pad_y_q, 5'b00000});

	// truncate toward zero after the 2^17 scale
	logic [52:0] prod_neg;
	logic [15:0] edge_val;
	assign prod_neg = 53'(-prod_q);
	always_comb begin
		if (prod_q[52]) begin
			edge_val = 16'(-(prod_neg >> 17));
		end else begin
			edge_val = prod_q[32:17];
		end
	end

	// overlap geometry between best and the entry just read
	logic signed [17:0] bl, bt, br, bb, el, et, er, eb, x1, x2, y1, y2;
	always_comb begin
		bl = 18'(signed'(best_q.left));
		bt = 18'(signed'(best_q.top));
		el = 18'(signed'(ram_rd.left));
		et = 18'(signed'(ram_rd.top));
		br = bl + $signed({2'b00, best_q.width});
		bb = bt + $signed({2'b00, best_q.height});
		er = el + $signed({2'b00, ram_rd.width});
		eb = et + $signed({2'b00, ram_rd.height});
		x1 = (bl > el) ? bl : el;
		y1 = (bt > et) ? bt : et;
		x2 = (br < er) ? br : er;
		y2 = (bb < eb) ? bb : eb;
	end

	logic [33:0] union_v;
	assign union_v = {2'b00, best_area_q} + {2'b00, prod_q[31:0]} - {2'b00, inter_q};

	logic suppress;
	assign suppress = ovl_q && ({2'b00, inter_q, 16'h0000} > {1'b0, prod_q[48:0]});

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_LL: begin
				mul_a = vx;
				mul_b = $signed({19'd0, scale_q});
			end
			S_LT: begin
				mul_a = vy;
				mul_b = $signed({19'd0, scale_q});
			end
			S_LW: begin
				mul_a = $signed({4'd0, bw_q});
				mul_b = $signed({19'd0, scale_q});
			end
			S_LH: begin
				mul_a = $signed({4'd0, bh_q});
				mul_b = $signed({19'd0, scale_q});
			end
			S_M1: begin
				mul_a = iw_q;
				mul_b = 35'(ih_q);
			end
			S_M2: begin
				mul_a = $signed({2'b00, ent_q.width});
				mul_b = $signed({19'd0, ent_q.height});
			end
			S_M3: begin
				mul_a = $signed({2'b00, iou_thr_q});
				mul_b = $signed({1'b0, union_v});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// ram write ports
	always_comb begin
		ram_we = (state_q == S_LWR);
		ram_wd.left   = dl_q;
		ram_wd.top    = dt_q;
		ram_wd.width  = dw_q;
		ram_wd.height = prod_q[31:16];
		ram_wd.score  = sc_q;
		ram_wd.cls    = cls_q;
		done_we = 1'b0;
		done_wa = cnt_q[AW-1:0];
		done_wd = 1'b0;
		if (state_q == S_LWR) begin
			done_we = 1'b1;
		end else if (state_q == S_MARK && have_best_q) begin
			done_we = 1'b1;
			done_wa = best_idx_q;
			done_wd = 1'b1;
		end else if (state_q == S_CMP && !skip_q && suppress) begin
			done_we = 1'b1;
			done_wa = idx_q[AW-1:0];
			done_wd = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_thr_q <= bdgn_pkg::SCORE_THR_RST;
			iou_thr_q   <= bdgn_pkg::IOU_THR_RST;
			pad_x_q     <= '0;
			pad_y_q     <= '0;
			scale_q     <= bdgn_pkg::SCALE_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				bdgn_pkg::REG_SCORE_THR: score_thr_q <= cfg.data;
				bdgn_pkg::REG_IOU_THR:   iou_thr_q   <= cfg.data;
				bdgn_pkg::REG_PAD_X:     pad_x_q     <= cfg.data[9:0];
				bdgn_pkg::REG_PAD_Y:     pad_y_q     <= cfg.data[9:0];
				bdgn_pkg::REG_SCALE:     scale_q     <= cfg.data;
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cx_q    <= in_ch.center_x;
			cy_q    <= in_ch.center_y;
			bw_q    <= in_ch.box_w;
			bh_q    <= in_ch.box_h;
			sc_q    <= in_ch.score;
			cls_q   <= in_ch.class_in;
			lastc_q <= in_ch.last_candidate;
		end
		if (state_q == S_LT) dl_q <= edge_val;
		if (state_q == S_LW) dt_q <= edge_val;
		if (state_q == S_LH) dw_q <= prod_q[31:16];
		if (state_q == S_GEO) begin
			ent_q <= ram_rd;
			iw_q  <= x2 - x1;
			ih_q  <= y2 - y1;
		end
		if (state_q == S_M2) inter_q <= prod_q[31:0];
		if (state_q == S_M3) ent_area_q <= prod_q[31:0];
		if (state_q == S_CMP && !skip_q && !suppress
				&& (!found_q || ent_q.score > nxt_q.score)) begin
			nxt_q      <= ent_q;
			nxt_idx_q  <= idx_q[AW-1:0];
			nxt_area_q <= ent_area_q;
		end
		if ((state_q == S_EMIT && !have_best_q) || (state_q == S_OUT && out_xfer)) begin
			best_q      <= nxt_q;
			best_idx_q  <= nxt_idx_q;
			best_area_q <= nxt_area_q;
		end
		if (state_q == S_EMIT) begin
			o_q <= have_best_q ? best_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			ovf_q       <= 1'b0;
			have_best_q <= 1'b0;
			found_q     <= 1'b0;
			skip_q      <= 1'b0;
			ovl_q       <= 1'b0;
			out_cnt_q   <= '0;
			o_last_q    <= 1'b0;
			o_none_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (in_ch.score > score_thr_q
								&& cnt_q < CW'(MAX_CANDIDATES)) begin
							state_q <= S_LL;
						end else begin
							if (in_ch.score > score_thr_q) ovf_q <= 1'b1;
							if (in_ch.last_candidate) begin
								state_q     <= S_MARK;
								have_best_q <= 1'b0;
								out_cnt_q   <= '0;
							end
						end
					end
				end
				S_LL: state_q <= S_LT;
				S_LT: state_q <= S_LW;
				S_LW: state_q <= S_LH;
				S_LH: state_q <= S_LWR;
				S_LWR: begin
					cnt_q <= cnt_q + 1'b1;
					if (lastc_q) begin
						state_q     <= S_MARK;
						have_best_q <= 1'b0;
						out_cnt_q   <= '0;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_MARK: begin
					found_q <= 1'b0;
					idx_q   <= '0;
					state_q <= (cnt_q == '0) ? S_EMIT : S_RD;
				end
				S_RD: state_q <= S_GEO;
				S_GEO: begin
					skip_q  <= done_rd;
					ovl_q   <= have_best_q && (x2 > x1) && (y2 > y1);
					state_q <= done_rd ? S_CMP : S_M1;
				end
				S_M1: state_q <= S_M2;
				S_M2: state_q <= S_M3;
				S_M3: state_q <= S_CMP;
				S_CMP: begin
					if (!skip_q && !suppress) found_q <= 1'b1;
					if (idx_q + 1'b1 == cnt_q) begin
						state_q <= S_EMIT;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_EMIT: begin
					if (have_best_q) begin
						o_none_q <= 1'b0;
						o_last_q <= !found_q
							|| (out_cnt_q == OCW'(bdgn_pkg::OUT_LIMIT - 1));
						state_q  <= S_OUT;
					end else if (found_q) begin
						have_best_q <= 1'b1;
						state_q     <= S_MARK;
					end else begin
						o_none_q <= 1'b1;
						o_last_q <= 1'b1;
						state_q  <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_xfer) begin
						if (o_last_q) begin
							cnt_q       <= '0;
							ovf_q       <= 1'b0;
							have_best_q <= 1'b0;
							state_q     <= S_IDLE;
						end else begin
							out_cnt_q <= out_cnt_q + 1'b1;
							state_q   <= S_MARK;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_ch.valid      = (state_q == S_OUT);
	assign out_ch.class_out  = o_q.cls;
	assign out_ch.confidence = o_q.score;
	assign out_ch.left       = signed'(o_q.left);
	assign out_ch.top        = signed'(o_q.top);
	assign out_ch.width      = o_q.width;
	assign out_ch.height     = o_q.height;
	assign out_ch.last       = o_last_q;
	assign out_ch.none_kept  = o_none_q;
	assign out_ch.overflow   = ovf_q;

	a_no_intake_while_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready) else $error("intake open while result pending");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_CANDIDATES)) else $error("store count beyond capacity");
	a_none_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.none_kept |-> out_ch.last) else $error("none_kept not last");
	a_frame_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && out_ch.last |=> cnt_q == '0 && !ovf_q)
		else $error("frame state not cleared");
endmodule

// File: verif/box_decode_greedy_nms_top_tb.sv
// testbench for box_decode_greedy_nms_top: random frames against a frame-level nms predictor
`timescale 1ns / 1ps
module box_decode_greedy_nms_top_tb;

	localparam int MAX_BOXES   = 64;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int ITEM_TARGET = 250;

	typedef struct packed {
		logic [bdgn_pkg::COORD_W-1:0] cx;
		logic [bdgn_pkg::COORD_W-1:0] cy;
		logic [bdgn_pkg::COORD_W-1:0] bw;
		logic [bdgn_pkg::COORD_W-1:0] bh;
		logic [bdgn_pkg::SCORE_W-1:0] score;
		logic [bdgn_pkg::CLASS_W-1:0] cls;
		logic                         last_cand;
	} candidate_t;

	typedef struct packed {
		logic [bdgn_pkg::CLASS_W-1:0] cls;
		logic [bdgn_pkg::SCORE_W-1:0] conf;
		logic [bdgn_pkg::EDGE_W-1:0]  left;
		logic [bdgn_pkg::EDGE_W-1:0]  top;
		logic [bdgn_pkg::EDGE_W-1:0]  width;
		logic [bdgn_pkg::EDGE_W-1:0]  height;
		logic                         last;
		logic                         none_kept;
		logic                         overflow;
	} detection_t;

	typedef struct {
		longint left, top, width, height;
	} image_box_t;

	class nms_scoreboard;
		int unsigned score_thr, iou_thr, pad_x, pad_y, scale;
		image_box_t  boxes[MAX_BOXES];
		int unsigned scores[MAX_BOXES];
		int unsigned classes[MAX_BOXES];
		int unsigned count;
		bit          dropped;
		detection_t  pending_dets[$];
		int          errors;
		int          frames, detections, overflow_frames;

		function new();
			score_thr = 32'(bdgn_pkg::SCORE_THR_RST);
			iou_thr   = 32'(bdgn_pkg::IOU_THR_RST);
			pad_x     = 0;
			pad_y     = 0;
			scale     = 32'(bdgn_pkg::SCALE_RST);
		endfunction

		function void note_config(bdgn_pkg::cfg_reg_t idx,
			logic [bdgn_pkg::CFG_DAT_W-1:0] value);
			case (idx)
				bdgn_pkg::REG_SCORE_THR: score_thr = 32'(value);
				bdgn_pkg::REG_IOU_THR: iou_thr = 32'(value);
				bdgn_pkg::REG_PAD_X: pad_x = 32'(value[bdgn_pkg::PAD_W-1:0]);
				bdgn_pkg::REG_PAD_Y: pad_y = 32'(value[bdgn_pkg::PAD_W-1:0]);
				bdgn_pkg::REG_SCALE: scale = 32'(value);
				default: ;
			endcase
		endfunction

		function void expect_det(detection_t d);
			pending_dets = {pending_dets, d};
		endfunction

		// letterbox removal and scaling, truncated toward zero
		function longint edge_of(longint centre, longint size, longint pad);
			longint p;
			p = (2 * centre - size - 32 * pad) * longint'(scale);
			if (p >= 0)
				return p >>> 17;
			return -((-p) >>> 17);
		endfunction

		function bit overlaps(image_box_t a, image_box_t b);
			longint x1, y1, x2, y2, inter, uni;
			x1 = (a.left > b.left) ? a.left : b.left;
			y1 = (a.top > b.top) ? a.top : b.top;
			x2 = (a.left + a.width < b.left + b.width) ? a.left + a.width : b.left + b.width;
			y2 = (a.top + a.height < b.top + b.height) ? a.top + a.height : b.top + b.height;
			if (x2 <= x1 || y2 <= y1)
				return 0;
			inter = (x2 - x1) * (y2 - y1);
			uni = a.width * a.height + b.width * b.height - inter;
			return inter * 65536 > longint'(iou_thr) * uni;
		endfunction

		function void note_candidate(candidate_t c);
			int unsigned rank[MAX_BOXES];
			bit          gone[MAX_BOXES];
			int          k, kept;
			detection_t  d;
			if (c.score > score_thr) begin
				if (count < MAX_BOXES) begin
					boxes[count].left   = edge_of(longint'(c.cx), longint'(c.bw),
						longint'(pad_x));
					boxes[count].top    = edge_of(longint'(c.cy), longint'(c.bh),
						longint'(pad_y));
					boxes[count].width  = (longint'(c.bw) * longint'(scale)) >> 16;
					boxes[count].height = (longint'(c.bh) * longint'(scale)) >> 16;
					scores[count]  = 32'(c.score);
					classes[count] = 32'(c.cls);
					count++;
				end else begin
					dropped = 1;
				end
			end
			if (!c.last_cand)
				return;
			// stable ranking, earlier arrival wins a tie
			for (int i = 0; i < count; i++) begin
				k = i;
				while (k > 0 && scores[rank[k-1]] < scores[i]) begin
					rank[k] = rank[k-1];
					k--;
				end
				rank[k] = i;
				gone[i] = 0;
			end
			kept = 0;
			for (int i = 0; i < count; i++) begin
				if (!gone[rank[i]]) begin
					if (kept < bdgn_pkg::OUT_LIMIT) begin
						d = '0;
						d.cls      = 8'(classes[rank[i]]);
						d.conf     = 16'(scores[rank[i]]);
						d.left     = 16'(boxes[rank[i]].left);
						d.top      = 16'(boxes[rank[i]].top);
						d.width    = 16'(boxes[rank[i]].width);
						d.height   = 16'(boxes[rank[i]].height);
						d.overflow = dropped;
						expect_det(d);
						kept++;
					end
					for (int j = i + 1; j < count; j++)
						if (!gone[rank[j]] && overlaps(boxes[rank[i]], boxes[rank[j]]))
							gone[rank[j]] = 1;
				end
			end
			if (kept == 0) begin
				d = '0;
				d.none_kept = 1;
				d.overflow  = dropped;
				expect_det(d);
			end
			pending_dets[$].last = 1;
			frames++;
			if (dropped)
				overflow_frames++;
			count   = 0;
			dropped = 0;
		endfunction

		function void check_result(detection_t got);
			detection_t want;
			if (pending_dets.size() == 0) begin
				$error("unexpected result transfer: %p", got);
				errors++;
				return;
			end
			want = pending_dets.pop_front();
			detections++;
			if (got.cls !== want.cls) begin
				$error("class_out expected %0d got %0d", want.cls, got.cls); errors++;
			end
			if (got.conf !== want.conf) begin
				$error("confidence expected %0d got %0d", want.conf, got.conf); errors++;
			end
			if (got.left !== want.left) begin
				$error("left expected %0d got %0d", $signed(want.left), $signed(got.left));
				errors++;
			end
			if (got.top !== want.top) begin
				$error("top expected %0d got %0d", $signed(want.top), $signed(got.top));
				errors++;
			end
			if (got.width !== want.width) begin
				$error("width expected %0d got %0d", want.width, got.width); errors++;
			end
			if (got.height !== want.height) begin
				$error("height expected %0d got %0d", want.height, got.height); errors++;
			end
			if (got.last !== want.last) begin
				$error("last expected %0d got %0d", want.last, got.last); errors++;
			end
			if (got.none_kept !== want.none_kept) begin
				$error("none_kept expected %0d got %0d", want.none_kept, got.none_kept);
				errors++;
			end
			if (got.overflow !== want.overflow) begin
				$error("overflow expected %0d got %0d", want.overflow, got.overflow); errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bdgn_in_if  in_ch();
	bdgn_out_if out_ch();
	bdgn_cfg_if cfg();

	box_decode_greedy_nms_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg(cfg)
	);

	nms_scoreboard sb = new();
	bit            no_gaps;
	int            cycles;
	int            sent;

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILURE");
			$finish;
		end
	end

	function int draw_gap();
		return no_gaps ? 0 : $urandom_range(0, 10);
	endfunction

	// result side: random stall before each transfer, none while no_gaps is set
	initial begin
		int stall;
		out_ch.ready = 0;
		@(posedge arst_n);
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				out_ch.ready <= 0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1;
			do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
			sb.check_result({out_ch.class_out, out_ch.confidence, out_ch.left, out_ch.top,
				out_ch.width, out_ch.height, out_ch.last, out_ch.none_kept, out_ch.overflow});
		end
	end

	task automatic send_candidate(candidate_t c);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_ch.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid          <= 1;
		in_ch.center_x       <= c.cx;
		in_ch.center_y       <= c.cy;
		in_ch.box_w          <= c.bw;
		in_ch.box_h          <= c.bh;
		in_ch.score          <= c.score;
		in_ch.class_in       <= c.cls;
		in_ch.last_candidate <= c.last_cand;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_candidate(c);
		sent++;
	endtask

	task automatic write_reg(bdgn_pkg::cfg_reg_t idx, logic [bdgn_pkg::CFG_DAT_W-1:0] value);
		cfg.valid <= 1;
		cfg.index <= idx;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
		sb.note_config(idx, value);
		cfg.valid <= 0;
		@(posedge clk);
	endtask

	// closes the input side and waits for every predicted result
	task automatic wait_drained();
		in_ch.valid <= 0;
		while (sb.pending_dets.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic candidate_t make_box(int cx, int cy, int bw, int bh, int score,
		int cls, bit last_cand);
		candidate_t c;
		c.cx = 14'(cx); c.cy = 14'(cy); c.bw = 14'(bw); c.bh = 14'(bh);
		c.score = 16'(score); c.cls = 8'(cls); c.last_cand = last_cand;
		return c;
	endfunction

	// clustered boxes so that nms has something to suppress, plus some noise
	task automatic random_frame(int n, bit overfill);
		candidate_t c;
		int base_x, base_y, prev_score;
		base_x = $urandom_range(0, 16383);
		base_y = $urandom_range(0, 16383);
		prev_score = $urandom_range(0, 65535);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				c.cx    = 14'($urandom);
				c.cy    = 14'($urandom);
				c.bw    = 14'($urandom);
				c.bh    = 14'($urandom);
				c.score = 16'($urandom);
				c.cls   = 8'($urandom);
			end else begin
				c.cx = 14'(base_x + $urandom_range(0, 256) - 128);
				c.cy = 14'(base_y + $urandom_range(0, 256) - 128);
				c.bw = 14'($urandom_range(16, 3000));
				c.bh = 14'($urandom_range(16, 3000));
				c.cls = 8'($urandom_range(0, 255));
				c.score = 16'(($urandom_range(0, 4) == 0) ? prev_score
					: $urandom_range(0, 65535));
			end
			if (overfill)
				c.score = 16'(16'hffff - $urandom_range(0, 3));
			prev_score = int'(c.score);
			c.last_cand = (i == n - 1);
			send_candidate(c);
		end
	endtask

	function automatic logic [bdgn_pkg::CFG_DAT_W-1:0] pick_value(int lo, int hi, int mid_hi);
		case ($urandom_range(0, 3))
			0: return 16'(lo);
			1: return 16'(hi);
			default: return 16'($urandom_range(lo, mid_hi));
		endcase
	endfunction

	initial begin
		int nframes;
		clk = 0;
		arst_n = 0;
		sent = 0;
		no_gaps = 0;
		in_ch.valid = 0;
		in_ch.center_x = '0;
		in_ch.center_y = '0;
		in_ch.box_w = '0;
		in_ch.box_h = '0;
		in_ch.score = '0;
		in_ch.class_in = '0;
		in_ch.last_candidate = 0;
		cfg.valid = 0;
		cfg.index = bdgn_pkg::REG_SCORE_THR;
		cfg.data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset settings: ties, an exact duplicate, touching boxes, score equal to threshold
		send_candidate(make_box(1600, 1600, 800, 800, 50000, 1, 0));
		send_candidate(make_box(1600, 1600, 800, 800, 40000, 2, 0));
		send_candidate(make_box(2400, 1600, 800, 800, 50000, 3, 0));
		send_candidate(make_box(1700, 1650, 800, 800, 45000, 4, 0));
		send_candidate(make_box(0, 0, 0, 0, 65535, 0, 0));
		send_candidate(make_box(16383, 16383, 16383, 16383, 65535, 255, 0));
		send_candidate(make_box(100, 100, 50, 50, 16384, 7, 0));
		send_candidate(make_box(5000, 5000, 100, 100, 0, 9, 1));
		// empty frame
		send_candidate(make_box(300, 300, 40, 40, 100, 5, 1));
		wait_drained();

		// far extremes of the decode
		write_reg(bdgn_pkg::REG_SCORE_THR, 16'd0);
		write_reg(bdgn_pkg::REG_PAD_X, 16'd1023);
		write_reg(bdgn_pkg::REG_PAD_Y, 16'd1023);
		write_reg(bdgn_pkg::REG_SCALE, 16'hffff);
		write_reg(bdgn_pkg::REG_IOU_THR, 16'd0);
		send_candidate(make_box(0, 0, 16383, 16383, 1, 10, 0));
		send_candidate(make_box(16383, 0, 0, 16383, 2, 11, 0));
		send_candidate(make_box(16383, 16383, 16383, 0, 3, 12, 1));
		wait_drained();
		write_reg(bdgn_pkg::REG_SCALE, 16'd0);
		write_reg(bdgn_pkg::REG_IOU_THR, 16'hffff);
		send_candidate(make_box(1000, 1000, 200, 200, 9, 13, 0));
		send_candidate(make_box(1000, 1000, 200, 200, 9, 14, 1));
		wait_drained();

		// random phases, each under its own register settings
		sent = 0;
		nframes = 0;
		while (sent < ITEM_TARGET) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			write_reg(bdgn_pkg::REG_SCORE_THR, pick_value(0, 65535, 40000));
			write_reg(bdgn_pkg::REG_IOU_THR, pick_value(0, 65535, 65535));
			write_reg(bdgn_pkg::REG_PAD_X, pick_value(0, 1023, 1023));
			write_reg(bdgn_pkg::REG_PAD_Y, pick_value(0, 1023, 1023));
			write_reg(bdgn_pkg::REG_SCALE, pick_value(0, 65535, 65535));
			repeat ($urandom_range(2, 5)) begin
				if (sent < ITEM_TARGET) begin
					if (nframes % 12 == 5 && sb.score_thr < 65532) begin
						random_frame($urandom_range(66, 72), 1);
					end else begin
						random_frame($urandom_range(1, 12), 0);
					end
					nframes++;
				end
			end
			wait_drained();
		end

		wait_drained();
		$display("covered %0d frames (%0d with dropped candidates), %0d result transfers checked",
			sb.frames, sb.overflow_frames, sb.detections);
		$display("all five registers swept through extremes and random settings");
		if (sb.errors == 0 && sb.pending_dets.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/bdgn_pkg.sv
hw/rtl/bdgn_if.sv
hw/rtl/bdgn_ram.sv
hw/rtl/box_decode_greedy_nms_top.sv
verif/box_decode_greedy_nms_top_tb.sv
